[rtl/lsa_pkg.sv]
// types and codes shared by the stack allocator and its checker
`timescale 1ns / 1ps

package lsa_pkg;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_ORDER    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_BYTES = 1'b1;

	localparam logic [31:0] REGION_BYTES_RESET = 32'd65536;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] size;
		logic [3:0]  align_log2;
		logic [31:0] block_address;
	} item_t;

	typedef struct packed {
		logic [31:0] address;
		logic [2:0]  status;
	} result_t;

endpackage

[rtl/lifo_stack_allocator_unit.sv]
// lifo stack allocator with the record stack held in synchronous memory
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_stall        lsa_pkg::item_t
//  result    out        result_valid / result_stall    lsa_pkg::result_t
//  config    in         cfg_we, cfg_index              cfg_wdata
//
//  each accepted item has its cursor aligned and its top record read as it is taken in;
//  in S_EXEC the record is checked against the request and the result is written.
//  S_EXEC waits while the result register still holds an untaken result.
//  the result register lets a new item be accepted while a result waits.
//  reset empties the record stack through its count; no clearing pass.
`timescale 1ns / 1ps

module lifo_stack_allocator_unit #(
	parameter int ADDR_BITS      = 32,
	parameter int RECORD_DEPTH   = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int MAX_ALIGN_LOG2 = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  lsa_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output lsa_pkg::result_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_wdata
);

	localparam int CW  = ADDR_BITS + 1;
	localparam int WW  = ((ADDR_BITS > 33) ? ADDR_BITS : 33) + 2;
	localparam int OW  = ((MAX_ALIGN_LOG2 > 7) ? MAX_ALIGN_LOG2 : 7) + 2;
	localparam int IW  = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int NW  = IW + 1;
	localparam int LGW = 5;
	localparam logic [WW-1:0] TOP   = WW'(1) << ADDR_BITS;
	localparam logic [WW-1:0] AMASK = TOP - WW'(1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic             state_q;
	logic [31:0]      region_base_q;
	logic [31:0]      region_bytes_q;
	logic [CW-1:0]    cursor_q;
	logic [NW-1:0]    count_q;
	lsa_pkg::item_t   item_s1;
	logic [WW-1:0]    aligned_s1;
	logic [WW-1:0]    end_s1;
	logic             result_valid_q;
	lsa_pkg::result_t result_q;

	logic [CW-1:0]    mem_cursor [RECORD_DEPTH];
	logic [31:0]      mem_len    [RECORD_DEPTH];
	logic [CW-1:0]    rd_cursor_s1;
	logic [31:0]      rd_size_s1;

	logic             accept;
	logic             exec_go;
	logic [WW-1:0]    base_m;
	logic [WW-1:0]    end_raw;
	logic [WW-1:0]    end_w;
	logic [WW-1:0]    cursor_w;
	logic [LGW-1:0]   lg_sat;
	logic [OW-1:0]    cur_lo;
	logic [OW-1:0]    amask;
	logic [OW-1:0]    gap;
	logic [OW-1:0]    bump;
	logic [OW-1:0]    off;
	logic [IW-1:0]    rd_idx;
	logic [CW-1:0]    cfg_cursor;

	logic [WW-1:0]    fin;
	logic [WW-1:0]    blk;
	logic             mem_we;
	logic [CW-1:0]    cursor_nx;
	logic [NW-1:0]    count_nx;
	lsa_pkg::result_t res_nx;

	assign accept       = item_valid && !item_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign exec_go      = (state_q == S_EXEC) && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// region end, clipped to the address space
	assign base_m   = WW'(region_base_q) & AMASK;
	assign end_raw  = base_m + WW'(region_bytes_q);
	assign end_w    = (end_raw > TOP) ? TOP : end_raw;
	assign cursor_w = WW'(cursor_q);
	assign rd_idx   = IW'(count_q - NW'(1));

	assign cfg_cursor = (cfg_index == lsa_pkg::REG_BASE) ?
		CW'(WW'(cfg_wdata) & AMASK) : CW'(base_m);

	// alignment offset from the low cursor bits
	always_comb begin
		lg_sat = (LGW'(item.align_log2) > LGW'(MAX_ALIGN_LOG2)) ?
			LGW'(MAX_ALIGN_LOG2) : LGW'(item.align_log2);
		cur_lo = cursor_w[OW-1:0];
		amask  = (OW'(1) << lg_sat) - OW'(1);
		gap    = (~cur_lo + OW'(1)) & amask;
		if (gap < OW'(HEADER_BYTES)) begin
			bump = (OW'(HEADER_BYTES) - gap + amask) & ~amask;
		end else begin
			bump = '0;
		end
		off = gap + bump;
	end

	// decision in the S_EXEC state
	always_comb begin
		fin       = aligned_s1 + WW'(item_s1.size);
		blk       = WW'(item_s1.block_address) & AMASK;
		mem_we    = 1'b0;
		cursor_nx = cursor_q;
		count_nx  = count_q;
		res_nx    = '{address: '0, status: lsa_pkg::ST_OK};
		case (item_s1.action)
			lsa_pkg::ACT_ALLOC: begin
				if (count_q >= NW'(RECORD_DEPTH)) begin
					res_nx.status = lsa_pkg::ST_FULL;
				end else if (fin > end_s1) begin
					res_nx.status = lsa_pkg::ST_NO_SPACE;
				end else begin
					mem_we         = 1'b1;
					cursor_nx      = CW'(fin);
					count_nx       = count_q + NW'(1);
					res_nx.address = aligned_s1[31:0];
				end
			end
			lsa_pkg::ACT_FREE: begin
				if (count_q == '0) begin
					res_nx.status = lsa_pkg::ST_EMPTY;
				end else if (blk + WW'(rd_size_s1) != cursor_w) begin
					res_nx.status = lsa_pkg::ST_ORDER;
				end else begin
					cursor_nx = rd_cursor_s1;
					count_nx  = count_q - NW'(1);
				end
			end
			lsa_pkg::ACT_CLEAR: begin
				cursor_nx = CW'(base_m);
				count_nx  = '0;
			end
			default: begin
			end
		endcase
	end

	// record stack memory
	always_ff @(posedge clk) begin
		if (exec_go && mem_we) begin
			mem_cursor[count_q[IW-1:0]] <= cursor_q;
			mem_len[count_q[IW-1:0]]    <= item_s1.size;
		end
		if (accept) begin
			rd_cursor_s1 <= mem_cursor[rd_idx];
			rd_size_s1   <= mem_len[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item;
			aligned_s1 <= cursor_w + WW'(off);
			end_s1     <= end_w;
		end
		if (exec_go) begin
			result_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			region_base_q  <= '0;
			region_bytes_q <= lsa_pkg::REGION_BYTES_RESET;
			cursor_q       <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lsa_pkg::REG_BASE) begin
					region_base_q <= cfg_wdata;
				end else begin
					region_bytes_q <= cfg_wdata;
				end
				cursor_q <= cfg_cursor;
				count_q  <= '0;
			end else if (exec_go) begin
				cursor_q <= cursor_nx;
				count_q  <= count_nx;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (exec_go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/lsa_checker.sv]
// port-level checks for the stack allocator, bound to the top level
`timescale 1ns / 1ps

module lsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input lsa_pkg::result_t result
);

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one item at a time: the input closes right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted while another is at work");

	// only a successful allocate carries an address
	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.address != '0) |-> result.status == lsa_pkg::ST_OK)
		else $error("address on a failed request");

	// a new result follows an accepted item
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without an item at work");

endmodule

bind lifo_stack_allocator_unit lsa_checker u_lsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
